// ===== sv/tbt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the thermistor beta temperature block
// no dependencies

package tbt_pkg;

  localparam int FRAC_BITS = 28;
  localparam int LOG_W     = 5 + FRAC_BITS;

  localparam logic [27:0]        LN2_Q28      = 28'd186065280;
  localparam logic [14:0]        T0_CENTI     = 15'd29815;
  localparam logic signed [17:0] TEMP_MAX     = 18'sd100000;
  localparam logic signed [17:0] ABS_ZERO_NEG = -18'sd27315;
  localparam logic signed [17:0] FAULT_TEMP   = -18'sd100;
  localparam logic [17:0]        ABS_ZERO     = 18'd27315;
  localparam logic [16:0]        Q_MAX        = 17'd127315;

  typedef enum logic [1:0] {
    REG_REF_MV   = 2'd0,
    REG_PULLUP   = 2'd1,
    REG_NOMINAL  = 2'd2,
    REG_BETA     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_FAULT = 2'd0,
    K_ZERO  = 2'd1,
    K_CALC  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [12:0] ref_mv;
    logic [19:0] pullup_ohms;
    logic [19:0] nominal_ohms;
    logic [13:0] beta;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] v;
    logic [12:0] d;
  } item_t;

endpackage

// ===== sv/tbt_front.sv =====
`timescale 1ns / 1ps
// front end: takes samples, sorts them into fault, zero and calc words,
// and holds them in a two-entry queue; uses tbt_pkg

module tbt_front (
  input  logic               clk,
  input  logic               rst,
  input  tbt_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [12:0]        sample_mv,
  output logic               q_valid,
  input  logic               q_ready,
  output tbt_pkg::item_t     q_item
);
  import tbt_pkg::*;

  item_t       slots [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  item_t       new_item;
  logic        push;
  logic        pop;

  always_comb begin
    new_item.v = sample_mv;
    new_item.d = cfg.ref_mv - sample_mv;
    if (cfg.ref_mv <= sample_mv) begin
      new_item.kind = K_FAULT;
    end else if (sample_mv == 13'd0 || cfg.pullup_ohms == 20'd0 ||
                 cfg.nominal_ohms == 20'd0 || cfg.beta == 14'd0) begin
      new_item.kind = K_ZERO;
    end else begin
      new_item.kind = K_CALC;
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slots[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= new_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/tbt_log2.sv =====
`timescale 1ns / 1ps
// iterative log2 in q28: leading-one search, then one mantissa squaring a cycle
// uses tbt_pkg

module tbt_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [19:0]                x,
  output logic                       busy,
  output logic [tbt_pkg::LOG_W-1:0]  result
);
  import tbt_pkg::*;

  logic [31:0]          m;
  logic [4:0]           ipart;
  logic [FRAC_BITS-1:0] frac;
  logic [4:0]           cnt;
  logic [4:0]           pos;
  logic [31:0]          m_start;
  logic [63:0]          sq;
  logic [32:0]          t;

  always_comb begin
    pos = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (x[i]) pos = 5'(i);
    end
  end

  assign m_start = 32'(x) << (5'd31 - pos);
  assign sq      = 64'(m) * 64'(m);
  assign t       = sq[63:31];
  assign result  = {ipart, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      m     <= m_start;
      ipart <= pos;
      frac  <= '0;
      cnt   <= 5'd0;
    end else if (busy) begin
      m    <= t[32] ? t[32:1] : t[31:0];
      frac <= {frac[FRAC_BITS-2:0], t[32]};
      cnt  <= cnt + 5'd1;
      if (cnt == 5'(FRAC_BITS - 1)) busy <= 1'b0;
    end
  end

endmodule

// ===== sv/tbt_back.sv =====
`timescale 1ns / 1ps
// back end: four log lanes, ln scaling, beta denominator, restoring divide,
// clamp and output register; uses tbt_pkg and tbt_log2

module tbt_back (
  input  logic                     clk,
  input  logic                     rst,
  input  tbt_pkg::cfg_t            cfg,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  tbt_pkg::item_t           q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [17:0]       temp_centi,
  output logic                     fault
);
  import tbt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_SUM, S_LN1, S_LN2, S_DEN, S_CHK, S_DIV, S_FIN, S_PUT
  } state_t;

  state_t              state;
  logic                lstart;
  logic [3:0]          lbusy;
  logic [LOG_W-1:0]    lres [4];
  logic [19:0]         lx [4];

  logic                neg;
  logic [33:0]         ymag;
  logic [59:0]         plo;
  logic [20:0]         bb;
  logic signed [31:0]  ln;
  logic [59:0]         num;
  logic signed [48:0]  den;
  logic [60:0]         rem;
  logic [63:0]         dsh;
  logic [4:0]          cnt;
  logic [16:0]         q;
  logic signed [17:0]  res_t;
  logic                res_f;

  logic signed [34:0]  y_sum;
  logic [29:0]         hiprod;
  logic [62:0]         p;
  logic [30:0]         lnmag;
  logic [60:0]         numr;
  logic                ge;

  assign lstart = (state == S_IDLE) && q_valid && (q_item.kind == K_CALC);
  assign lx[0]  = cfg.pullup_ohms;
  assign lx[1]  = 20'(q_item.v);
  assign lx[2]  = 20'(q_item.d);
  assign lx[3]  = cfg.nominal_ohms;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    tbt_log2 u_log (
      .clk    (clk),
      .rst    (rst),
      .start  (lstart),
      .x      (lx[g]),
      .busy   (lbusy[g]),
      .result (lres[g])
    );
  end

  assign q_ready = (state == S_IDLE);

  always_comb begin
    y_sum  = $signed(35'(lres[0])) + $signed(35'(lres[1]))
           - $signed(35'(lres[2])) - $signed(35'(lres[3]));
    hiprod = 30'(ymag[33:32]) * 30'(LN2_Q28);
    p      = 63'(plo) + (63'(hiprod) << 32) + (63'd1 << 31);
    lnmag  = p[62:32];
    numr   = 61'(num) + 61'(den[47:1]);
    ge     = 64'(rem) >= dsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_PUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              K_FAULT: begin
                res_t <= FAULT_TEMP;
                res_f <= 1'b1;
                state <= S_PUT;
              end
              K_CALC: begin
                res_f <= 1'b0;
                state <= S_LOG;
              end
              default: begin
                res_t <= ABS_ZERO_NEG;
                res_f <= 1'b0;
                state <= S_PUT;
              end
            endcase
          end
        end
        S_LOG: begin
          if (lbusy == 4'd0) state <= S_SUM;
        end
        S_SUM: begin
          neg   <= y_sum[34];
          ymag  <= y_sum[34] ? 34'(-y_sum) : 34'(y_sum);
          state <= S_LN1;
        end
        S_LN1: begin
          plo   <= 60'(ymag[31:0]) * 60'(LN2_Q28);
          bb    <= 21'(cfg.beta) * 21'd100;
          state <= S_LN2;
        end
        S_LN2: begin
          ln    <= neg ? -$signed({1'b0, lnmag}) : $signed({1'b0, lnmag});
          num   <= 60'(36'(bb) * 36'(T0_CENTI)) << 24;
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= ln * $signed(49'(T0_CENTI)) + $signed({4'b0, bb, 24'b0});
          state <= S_CHK;
        end
        S_CHK: begin
          if (den[48] || den == 49'sd0) begin
            res_t <= ABS_ZERO_NEG;
            state <= S_PUT;
          end else if ((numr >> 17) >= 61'(den[47:0])) begin
            // quotient at least 2^17, well past the hot limit
            res_t <= TEMP_MAX;
            state <= S_PUT;
          end else begin
            rem   <= numr;
            dsh   <= 64'(den[47:0]) << 16;
            cnt   <= 5'd16;
            q     <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) rem <= rem - 61'(dsh);
          q   <= {q[15:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_FIN;
        end
        S_FIN: begin
          if (q > Q_MAX) res_t <= TEMP_MAX;
          else res_t <= $signed(18'(q) - ABS_ZERO);
          state <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            temp_centi <= res_t;
            fault      <= res_f;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/thermistor_beta_temperature.sv =====
`timescale 1ns / 1ps
// ntc thermistor temperature (beta equation) from a divider voltage in mV
// top level: configuration registers, tbt_front, tbt_back; uses tbt_pkg
//
// usage
//   input channel in_valid/in_ready carries one sample_mv word; output channel
//   out_valid/out_ready carries temp_centi (0.01 C, signed) and fault.
//   config registers are written via cfg_we/cfg_index/cfg_data while idle:
//   0 ref_mv, 1 pullup_ohms, 2 nominal_ohms, 3 beta.
//   a computed word goes from acceptance through mantissa squaring in four
//   parallel log2 lanes, ln and denominator scaling, a range check that may
//   clamp the result, and restoring division, then to out_valid. fault and
//   zero words go straight to the output register. one word is worked at a
//   time: the back end takes no new word until the last is in the output register.
//   a two-entry queue in front takes new samples while the back end works or
//   the output waits; a stalled receiver holds the output register and the
//   back end, and in_ready drops once the queue is full.
//   reset restores the default register values and empties queue and output.

module thermistor_beta_temperature (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [12:0]         sample_mv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  temp_centi,
  output logic                fault,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data
);
  import tbt_pkg::*;

  cfg_t   cfg;
  logic   q_valid;
  logic   q_ready;
  item_t  q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_mv       <= 13'd3300;
      cfg.pullup_ohms  <= 20'd4700;
      cfg.nominal_ohms <= 20'd100000;
      cfg.beta         <= 14'd3950;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REF_MV:  cfg.ref_mv       <= cfg_data[12:0];
        REG_PULLUP:  cfg.pullup_ohms  <= cfg_data;
        REG_NOMINAL: cfg.nominal_ohms <= cfg_data;
        REG_BETA:    cfg.beta         <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  tbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_mv (sample_mv),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  tbt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .temp_centi (temp_centi),
    .fault      (fault)
  );

endmodule
